// ===== rtl/pse_pkg.sv =====
// Package for the postfix stack evaluator: constants, status codes, types.
// No dependencies.
`timescale 1ns / 1ps
package pse_pkg;
    localparam int STACK_DEPTH = 64;
    localparam int PTR_W = $clog2(STACK_DEPTH);
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int DATA_W = 64;

    typedef logic [DATA_W-1:0] data_t;
    typedef logic [1:0] status_t;
    typedef logic [2:0] op_t;

    localparam status_t ST_OK      = 2'd0;
    localparam status_t ST_UNKNOWN = 2'd1;
    localparam status_t ST_INVALID = 2'd2;
    localparam status_t ST_FULL    = 2'd3;

    localparam op_t OP_ADD = 3'd0;
    localparam op_t OP_SUB = 3'd1;
    localparam op_t OP_MUL = 3'd2;
    localparam op_t OP_DIV = 3'd3;

    localparam data_t POS_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam data_t NEG_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef struct packed {
        logic start;
        op_t  op;
    } alu_cmd_t;

    typedef struct packed {
        logic done;
    } alu_sts_t;
endpackage

// ===== rtl/pse_alu.sv =====
// Shared multicycle arithmetic unit: saturating add, subtract, multiply, divide.
// Depends on pse_pkg.
`timescale 1ns / 1ps
module pse_alu (
    input  logic              aclk,
    input  logic              aresetn,
    input  pse_pkg::alu_cmd_t cmd,
    input  pse_pkg::data_t    lhs,
    input  pse_pkg::data_t    rhs,
    output pse_pkg::alu_sts_t sts,
    output pse_pkg::data_t    result
);
    import pse_pkg::*;

    typedef enum logic [2:0] {A_IDLE, A_MUL0, A_MUL1, A_MUL2, A_MUL3, A_MULF, A_DIV, A_DONE}
        astate_t;

    astate_t     state_reg;
    logic        neg_reg;
    data_t       ma_reg, mb_reg;
    logic [127:0] acc_reg;
    logic [127:0] num_reg;
    logic [63:0]  rem_reg;
    data_t       q_reg;
    logic        ovf_reg;
    logic [6:0]  cnt_reg;
    data_t       result_reg;

    data_t  ma_c, mb_c, sum_c, dif_c;
    logic   an, bn;
    logic [63:0] pp;
    logic [31:0] pa, pb;
    logic [64:0] rsh, rsub;

    function automatic data_t sat(input logic neg, input data_t mag, input logic ovf);
        if (!neg) return (ovf || mag[63]) ? POS_MAX : mag;
        if (ovf || mag > NEG_MIN) return NEG_MIN;
        return data_t'(-mag);
    endfunction

    always_comb begin
        an = lhs[63];
        bn = rhs[63];
        ma_c = an ? data_t'(-lhs) : lhs;
        mb_c = bn ? data_t'(-rhs) : rhs;
        sum_c = lhs + rhs;
        dif_c = lhs - rhs;
        unique case (state_reg)
            A_MUL0:  begin pa = ma_reg[31:0];  pb = mb_reg[31:0];  end
            A_MUL1:  begin pa = ma_reg[63:32]; pb = mb_reg[31:0];  end
            A_MUL2:  begin pa = ma_reg[31:0];  pb = mb_reg[63:32]; end
            default: begin pa = ma_reg[63:32]; pb = mb_reg[63:32]; end
        endcase
        pp = 64'(pa) * 64'(pb);
        rsh = {rem_reg, num_reg[127]};
        rsub = rsh - {1'b0, mb_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= A_IDLE;
        end else begin
            unique case (state_reg)
                A_IDLE: begin
                    if (cmd.start) begin
                        neg_reg <= an ^ bn;
                        ma_reg <= ma_c;
                        mb_reg <= mb_c;
                        acc_reg <= '0;
                        rem_reg <= '0;
                        q_reg <= '0;
                        ovf_reg <= 1'b0;
                        num_reg <= {32'd0, ma_c, 32'd0};
                        cnt_reg <= 7'd127;
                        case (cmd.op)
                            OP_ADD: begin
                                result_reg <= (an == bn && sum_c[63] != an)
                                              ? (an ? NEG_MIN : POS_MAX) : sum_c;
                                state_reg <= A_DONE;
                            end
                            OP_SUB: begin
                                result_reg <= (an != bn && dif_c[63] != an)
                                              ? (an ? NEG_MIN : POS_MAX) : dif_c;
                                state_reg <= A_DONE;
                            end
                            OP_MUL: state_reg <= A_MUL0;
                            default: begin
                                if (mb_c == '0) begin
                                    result_reg <= an ? NEG_MIN : POS_MAX;
                                    state_reg <= A_DONE;
                                end else begin
                                    state_reg <= A_DIV;
                                end
                            end
                        endcase
                    end
                end
                A_MUL0: begin acc_reg <= acc_reg + 128'(pp);         state_reg <= A_MUL1; end
                A_MUL1: begin acc_reg <= acc_reg + (128'(pp) << 32); state_reg <= A_MUL2; end
                A_MUL2: begin acc_reg <= acc_reg + (128'(pp) << 32); state_reg <= A_MUL3; end
                A_MUL3: begin acc_reg <= acc_reg + (128'(pp) << 64); state_reg <= A_MULF; end
                A_MULF: begin
                    result_reg <= sat(neg_reg, acc_reg[95:32], acc_reg[127:96] != '0);
                    state_reg <= A_DONE;
                end
                A_DIV: begin
                    // one quotient bit per cycle, restoring
                    num_reg <= {num_reg[126:0], 1'b0};
                    if (q_reg[63]) ovf_reg <= 1'b1;
                    if (!rsub[64]) begin
                        rem_reg <= rsub[63:0];
                        q_reg <= {q_reg[62:0], 1'b1};
                    end else begin
                        rem_reg <= rsh[63:0];
                        q_reg <= {q_reg[62:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg - 7'd1;
                    if (cnt_reg == '0) state_reg <= A_DONE;
                end
                A_DONE: state_reg <= A_IDLE;
                default: state_reg <= A_IDLE;
            endcase
            if (state_reg == A_DIV && cnt_reg == '0)
                result_reg <= sat(neg_reg, rsub[64] ? {q_reg[62:0], 1'b0} : {q_reg[62:0], 1'b1},
                                  ovf_reg || q_reg[63]);
        end
    end

    assign sts.done = (state_reg == A_DONE);
    assign result = result_reg;
endmodule

// ===== rtl/postfix_stack_evaluator_top.sv =====
// Top level of the postfix stack evaluator: token sequencer and operand stack.
// Depends on pse_pkg and pse_alu.
`timescale 1ns / 1ps
//  channel | direction | ports
//  s_      | in        | s_valid s_ready s_req_type s_operand_value s_op_code s_end_of_expr
//  m_      | out       | m_valid m_ready m_result_value m_status
// An operand or ignored token goes from idle to S_FIN; an operator reads both operands via the
// stack memory's single read port in S_RD_R and S_RD_L, starts pse_alu (whose divider gives one
// quotient bit per cycle) in S_ALU and waits in S_WAIT; a last token then passes S_OUT.
// Reset clears count and error; stack contents are undefined.
// s_ready is low while a token is in work or a result beat waits on m_ready.
module postfix_stack_evaluator_top (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_req_type,
    input  logic signed [63:0]    s_operand_value,
    input  logic [2:0]            s_op_code,
    input  logic                  s_end_of_expr,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic signed [63:0]    m_result_value,
    output logic [1:0]            m_status
);
    import pse_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_RD_R, S_RD_L, S_ALU, S_WAIT, S_FIN, S_OUT} state_t;

    state_t          state_reg;
    logic [CNT_W-1:0] cnt_reg;
    status_t         err_reg;
    logic            end_reg;
    op_t             op_reg;
    data_t           rhs_reg, lhs_reg;
    data_t           rd_reg;
    logic            m_valid_reg;
    data_t           m_value_reg;
    status_t         m_status_reg;

    data_t           mem [STACK_DEPTH];
    logic            wr_en;
    logic [PTR_W-1:0] wr_addr, rd_addr;
    data_t           wr_data;

    alu_cmd_t        alu_cmd;
    alu_sts_t        alu_sts;
    data_t           alu_res;

    pse_alu u_alu (
        .aclk(aclk), .aresetn(aresetn), .cmd(alu_cmd),
        .lhs(lhs_reg), .rhs(rhs_reg), .sts(alu_sts), .result(alu_res)
    );

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        rd_reg <= mem[rd_addr];
    end

    logic accept;
    assign accept = s_valid && s_ready;
    assign s_ready = (state_reg == S_IDLE) && !m_valid_reg;

    always_comb begin
        wr_en = 1'b0;
        wr_addr = cnt_reg[PTR_W-1:0];
        wr_data = s_operand_value;
        rd_addr = PTR_W'(cnt_reg - CNT_W'(1));
        if (state_reg == S_IDLE && accept && err_reg == ST_OK && !s_req_type
            && cnt_reg != CNT_W'(STACK_DEPTH))
            wr_en = 1'b1;
        if (state_reg == S_RD_R) rd_addr = PTR_W'(cnt_reg - CNT_W'(2));
        if (state_reg == S_IDLE) rd_addr = PTR_W'(cnt_reg - CNT_W'(1));
        if (state_reg == S_WAIT && alu_sts.done) begin
            wr_en = 1'b1;
            wr_addr = PTR_W'(cnt_reg - CNT_W'(2));
            wr_data = alu_res;
        end
        if (state_reg == S_FIN) rd_addr = '0;
        alu_cmd.start = (state_reg == S_ALU);
        alu_cmd.op = op_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg <= '0;
            err_reg <= ST_OK;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        end_reg <= s_end_of_expr;
                        op_reg <= s_op_code;
                        state_reg <= S_FIN;
                        if (err_reg == ST_OK) begin
                            if (!s_req_type) begin
                                if (cnt_reg == CNT_W'(STACK_DEPTH)) err_reg <= ST_FULL;
                                else cnt_reg <= cnt_reg + CNT_W'(1);
                            end else if (cnt_reg == '0) begin
                                err_reg <= ST_INVALID;
                            end else if (s_op_code > OP_DIV) begin
                                err_reg <= ST_UNKNOWN;
                            end else if (cnt_reg == CNT_W'(1)) begin
                                err_reg <= ST_INVALID;
                            end else begin
                                state_reg <= S_RD_R;
                            end
                        end
                    end
                end
                S_RD_R: begin
                    // top entry read was issued in idle
                    rhs_reg <= rd_reg;
                    state_reg <= S_RD_L;
                end
                S_RD_L: begin
                    lhs_reg <= rd_reg;
                    state_reg <= S_ALU;
                end
                S_ALU: state_reg <= S_WAIT;
                S_WAIT: begin
                    if (alu_sts.done) begin
                        cnt_reg <= cnt_reg - CNT_W'(1);
                        state_reg <= S_FIN;
                    end
                end
                S_FIN: state_reg <= end_reg ? S_OUT : S_IDLE;
                S_OUT: begin
                    m_valid_reg <= 1'b1;
                    if (err_reg != ST_OK) begin
                        m_status_reg <= err_reg;
                        m_value_reg <= '0;
                    end else if (cnt_reg != CNT_W'(1)) begin
                        m_status_reg <= ST_INVALID;
                        m_value_reg <= '0;
                    end else begin
                        m_status_reg <= ST_OK;
                        m_value_reg <= rd_reg;
                    end
                    cnt_reg <= '0;
                    err_reg <= ST_OK;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_result_value = m_value_reg;
    assign m_status = m_status_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(STACK_DEPTH)) else $error("stack count beyond depth");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !s_ready) else $error("ready while busy");
    a_err_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT) |=> (err_reg == ST_OK && cnt_reg == '0 && m_valid))
        else $error("expression state not cleared after result");
endmodule
